>>> rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and codes of the scalar Kalman filter core: item kinds,
// configuration register indexes and the status bundle of the serial units.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_PRELOAD = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_ERROR     = 2'd0,
    REG_PROCESS_NOISE     = 2'd1,
    REG_MEASUREMENT_NOISE = 2'd2,
    REG_UNUSED            = 2'd3
  } reg_idx_t;

  // Status of a serial arithmetic unit. done pulses for one cycle once the
  // result register holds the final value.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> rtl/skf_serial_div.sv
// ----------------------------------------------------------------------------
// skf_serial_div
// Restoring divider, one quotient bit per cycle. Computes
// floor(num * 2^(Q_W-1) / den) for num <= den, so the quotient fits Q_W bits.
// ----------------------------------------------------------------------------
module skf_serial_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 33,
  parameter int Q_W   = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [NUM_W-1:0]       num,
  input  logic [DEN_W-1:0]       den,
  output logic [Q_W-1:0]         quotient,
  output skf_pkg::unit_stat_t    stat
);

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic             ge;
  logic [REM_W-1:0] rem_sub;

  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt = {rem_sub[REM_W-2:0], 1'b0};
    q_nxt   = {q_r[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num);
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/skf_serial_mult.sv
// ----------------------------------------------------------------------------
// skf_serial_mult
// Shift-add multiplier, one multiplier bit per cycle: signed multiplicand
// times unsigned multiplier, full-width signed product.
// ----------------------------------------------------------------------------
module skf_serial_mult #(
  parameter int MCAND_W = 33,
  parameter int MPLR_W  = 17
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [MCAND_W-1:0]         mcand,
  input  logic        [MPLR_W-1:0]          mplr,
  output logic signed [MCAND_W+MPLR_W-1:0]  product,
  output skf_pkg::unit_stat_t               stat
);

  localparam int CNT_W = $clog2(MPLR_W + 1);

  logic signed [MCAND_W:0]   hi_r;
  logic        [MPLR_W-1:0]  lo_r;
  logic signed [MCAND_W-1:0] mcand_r;
  logic        [CNT_W-1:0]   cnt_r;
  logic                      busy_r, done_r;
  logic signed [MCAND_W:0]   sum;

  // Partial sum stays within the multiplicand range plus one bit.
  assign sum = hi_r + (lo_r[0] ? {mcand_r[MCAND_W-1], mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MPLR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r    <= '0;
      lo_r    <= mplr;
      mcand_r <= mcand;
    end else if (busy_r) begin
      hi_r <= {sum[MCAND_W], sum[MCAND_W:1]};
      lo_r <= {sum[0], lo_r[MPLR_W-1:1]};
    end
  end

  assign product   = {hi_r[MCAND_W-1:0], lo_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional constant-model Kalman filter in fixed point, built from a
// bit-serial divider and two bit-serial multipliers.
// ----------------------------------------------------------------------------
// One filter update runs a prediction state that also starts the serial
// divider, the divider that forms the gain (one quotient bit per cycle),
// and the two shift-add multipliers that run side by side (new covariance
// and estimate step). Values are Q16.16 at the default FRACTION_BITS. A
// sample item costs one update plus an accept state and a state that loads
// the result register, a preload item PRELOAD_STEPS updates plus the
// accept and load states, and a restart or unused kind only the accept and
// load states. The core works on one item at a time; it accepts the next
// item while the previous result still waits on the output, and only holds
// back the finished result if that earlier transfer has not yet happened.
// Configuration writes are always accepted and should be issued only while
// the core is idle.
module scalar_kalman_filter_core #(
  parameter int PRELOAD_STEPS = 10,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Item input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [skf_pkg::KIND_W-1:0]            in_kind,
  input  logic signed [skf_pkg::DATA_W-1:0]     in_sample,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [skf_pkg::DATA_W-1:0]     out_estimate_out,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]            cfg_data
);

  localparam int DW    = skf_pkg::DATA_W;
  localparam int QW    = FRACTION_BITS + 1;       // gain width, holds 1.0
  localparam int DEN_W = DW + 1;                  // exact denominator
  localparam int PW    = DEN_W + QW;              // product width
  localparam int SCW   = $clog2(PRELOAD_STEPS + 1);

  localparam logic [QW-1:0] GAIN_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [DW-1:0] RST_INITIAL_ERROR     = DW'(64'd1 << FRACTION_BITS);
  localparam logic [DW-1:0] RST_PROCESS_NOISE     = DW'(64'd10 << FRACTION_BITS);
  localparam logic [DW-1:0] RST_MEASUREMENT_NOISE = DW'(64'd9 << FRACTION_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_DIV,
    S_MUL,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DW-1:0]          init_err_r, proc_noise_r, meas_noise_r;
  logic [DW-1:0]          cov_r, cov_nxt;
  logic signed [DW-1:0]   est_r, est_nxt;
  logic signed [DW-1:0]   sample_r, sample_nxt;
  logic [DW-1:0]          pred_r, pred_nxt;
  logic                   den_zero_r, den_zero_nxt;
  logic [SCW-1:0]         left_r, left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]   out_est_r, out_est_nxt;

  // Prediction datapath: saturating covariance plus process noise, and the
  // exact 33-bit denominator of the gain.
  logic [DW:0]            pred_sum;
  logic [DW-1:0]          pred_sat;
  logic [DEN_W-1:0]       denom;

  logic [QW-1:0]          div_q;
  logic [QW-1:0]          gain;
  logic [QW-1:0]          gain_rest;
  logic signed [DEN_W-1:0] diff;
  logic signed [PW-1:0]   cov_prod, step_prod;
  logic [DW-1:0]          cov_new;
  logic signed [DW-1:0]   est_new;
  logic                   div_start, mul_start;
  skf_pkg::unit_stat_t    div_stat, cov_stat, step_stat;

  assign pred_sum = {1'b0, cov_r} + {1'b0, proc_noise_r};
  assign pred_sat = pred_sum[DW] ? {DW{1'b1}} : pred_sum[DW-1:0];
  assign denom    = {1'b0, pred_sat} + {1'b0, meas_noise_r};

  // A zero denominator means a zero gain: covariance and estimate stay.
  assign gain      = den_zero_r ? '0 : div_q;
  assign gain_rest = GAIN_ONE - gain;
  assign diff      = $signed({sample_r[DW-1], sample_r}) - $signed({est_r[DW-1], est_r});

  assign div_start = (state_r == S_PRED);
  assign mul_start = (state_r == S_DIV) && div_stat.done;

  skf_serial_div #(
    .NUM_W (DW),
    .DEN_W (DEN_W),
    .Q_W   (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (pred_sat),
    .den      (denom),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // (1 - gain) * predicted; the predicted value is never negative, so it
  // enters as a zero-extended signed multiplicand.
  skf_serial_mult #(
    .MCAND_W (DEN_W),
    .MPLR_W  (QW)
  ) u_cov_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   ($signed({1'b0, pred_r})),
    .mplr    (gain_rest),
    .product (cov_prod),
    .stat    (cov_stat)
  );

  // gain * (sample - estimate), signed.
  skf_serial_mult #(
    .MCAND_W (DEN_W),
    .MPLR_W  (QW)
  ) u_step_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (diff),
    .mplr    (gain),
    .product (step_prod),
    .stat    (step_stat)
  );

  // Dropping the low fraction bits of the signed product is a floor, which
  // is the rounding the estimate step needs. The new estimate always lies
  // between the old one and the sample, so 32 bits are enough.
  assign cov_new = cov_prod[FRACTION_BITS +: DW];
  assign est_new = est_r + step_prod[FRACTION_BITS +: DW];

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_estimate_out = out_est_r;
  assign cfg_ready        = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cov_nxt       = cov_r;
    est_nxt       = est_r;
    sample_nxt    = sample_r;
    pred_nxt      = pred_r;
    den_zero_nxt  = den_zero_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r;
    out_est_nxt   = out_est_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          unique case (skf_pkg::kind_t'(in_kind))
            skf_pkg::KIND_SAMPLE: begin
              left_nxt  = SCW'(1);
              state_nxt = S_PRED;
            end
            skf_pkg::KIND_PRELOAD: begin
              left_nxt  = SCW'(PRELOAD_STEPS);
              state_nxt = S_PRED;
            end
            skf_pkg::KIND_RESTART: begin
              cov_nxt   = init_err_r;
              state_nxt = S_FIN;
            end
            skf_pkg::KIND_NONE: begin
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_PRED: begin
        pred_nxt     = pred_sat;
        den_zero_nxt = (denom == '0);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (cov_stat.done) begin
          cov_nxt = cov_new;
          est_nxt = est_new;
          if (left_r == SCW'(1)) begin
            state_nxt = S_FIN;
          end else begin
            left_nxt  = left_r - 1'b1;
            state_nxt = S_PRED;
          end
        end
      end
      S_FIN: begin
        // Wait until the output register is free or is emptied this cycle.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_est_nxt   = est_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      cov_r        <= RST_INITIAL_ERROR;
      est_r        <= '0;
      init_err_r   <= RST_INITIAL_ERROR;
      proc_noise_r <= RST_PROCESS_NOISE;
      meas_noise_r <= RST_MEASUREMENT_NOISE;
      left_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cov_r       <= cov_nxt;
      est_r       <= est_nxt;
      left_r      <= left_nxt;
      if (cfg_valid) begin
        unique case (skf_pkg::reg_idx_t'(cfg_index))
          skf_pkg::REG_INITIAL_ERROR:     init_err_r   <= cfg_data;
          skf_pkg::REG_PROCESS_NOISE:     proc_noise_r <= cfg_data;
          skf_pkg::REG_MEASUREMENT_NOISE: meas_noise_r <= cfg_data;
          skf_pkg::REG_UNUSED:            ;
          default:                        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    pred_r     <= pred_nxt;
    den_zero_r <= den_zero_nxt;
    out_est_r  <= out_est_nxt;
  end

  // The gain never exceeds one.
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && div_stat.done |-> gain <= GAIN_ONE)
    else $error("gain above one");

  // Shrinking the covariance never makes it larger than the prediction.
  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) && cov_stat.done |-> cov_new <= pred_r)
    else $error("covariance grew in update");

  // Both multipliers are started together and finish together.
  a_mult_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    cov_stat.done == step_stat.done)
    else $error("multipliers out of step");

  // The divider is never running while the multipliers are.
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_stat.busy && cov_stat.busy))
    else $error("divider and multiplier busy together");

  // A finished result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_valid_r && !out_ready |=> out_valid_r && state_r == S_FIN)
    else $error("pending result overwritten");

endmodule

>>> dv/scalar_kalman_filter_core_test.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core_test
// Self-checking testbench for the scalar Kalman filter core. A scoreboard
// keeps its own copy of the filter state and register file, predicts the
// estimate returned for every accepted item, and compares each transfer on
// the result channel against the oldest prediction. Stimulus is a directed
// set of corner cases followed by randomized phases under several register
// settings, with random gaps on the item channel and random back-pressure on
// the result channel.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam int FRAC = 16;
  localparam int PRELOAD = 10;
  localparam realtime HALF_PERIOD = 10ns;
  // The slowest legal item is a preload of ten updates. With the longest
  // sender gap and receiver stall on top, the 1300 items stay well below
  // this limit, so it only trips on a hang.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 160;
  // Quiet time at the end, long enough for a preload to finish.
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS = 20;

  // The scoreboard tracks the filter state and the queue of estimates that
  // the core still owes on its result channel.
  class estimate_tracker;
    logic [31:0]        initial_error;
    logic [31:0]        process_noise;
    logic [31:0]        measurement_noise;
    logic signed [31:0] estimate;
    logic [31:0]        covariance;
    logic [31:0]        expected_q[$];
    int                 checked;
    int                 mismatches;
    int                 kind_count[4];

    function new();
      initial_error     = 32'd1 << FRAC;
      process_noise     = 32'd10 << FRAC;
      measurement_noise = 32'd9 << FRAC;
      estimate          = '0;
      covariance        = 32'd1 << FRAC;
      checked           = 0;
      mismatches        = 0;
      kind_count        = '{default: 0};
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_INITIAL_ERROR:     initial_error = data;
        REG_PROCESS_NOISE:     process_noise = data;
        REG_MEASUREMENT_NOISE: measurement_noise = data;
        default: ;
      endcase
    endfunction

    // One predict/correct step. All intermediates fit comfortably in 64 bits,
    // and an arithmetic right shift gives the floor the core must apply.
    function void filter_update(logic signed [31:0] sample);
      longint one_fix;
      longint predicted;
      longint denom;
      longint gain;
      longint diff;
      longint step;
      longint next_cov;
      longint next_est;
      one_fix   = longint'(1) <<< FRAC;
      predicted = {32'd0, covariance} + {32'd0, process_noise};
      if (predicted > 64'hFFFF_FFFF) begin
        predicted = 64'hFFFF_FFFF;
      end
      denom = predicted + {32'd0, measurement_noise};
      gain  = (denom != 0) ? (predicted <<< FRAC) / denom : 0;
      if (gain > one_fix) begin
        gain = one_fix;
      end
      next_cov   = ((one_fix - gain) * predicted) >>> FRAC;
      covariance = next_cov[31:0];
      diff       = longint'(sample) - longint'(estimate);
      step       = (gain * diff) >>> FRAC;
      next_est   = longint'(estimate) + step;
      estimate   = next_est[31:0];
    endfunction

    function void note_item(kind_t kind, logic signed [31:0] sample);
      int i;
      kind_count[int'(kind)]++;
      case (kind)
        KIND_SAMPLE: filter_update(sample);
        KIND_PRELOAD: begin
          for (i = 0; i < PRELOAD; i++) begin
            filter_update(sample);
          end
        end
        KIND_RESTART: covariance = initial_error;
        default: ;
      endcase
      expected_q.push_back(estimate);
    endfunction

    function void check_estimate(logic signed [31:0] actual);
      logic signed [31:0] wanted;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: estimate %0d (0x%08h) arrived with none expected",
                   $time, actual, actual);
        end
      end else begin
        wanted = expected_q.pop_front();
        checked++;
        if (actual !== wanted) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: estimate mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, wanted, wanted, actual, actual);
          end
        end
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [KIND_W-1:0]                   in_kind = '0;
  logic signed [DATA_W-1:0]            in_sample = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [DATA_W-1:0]            out_estimate_out;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [CFG_IDX_W-1:0]                cfg_index = '0;
  logic [DATA_W-1:0]                   cfg_data = '0;

  estimate_tracker sb = new();

  // When set, neither side inserts gaps or stalls, so the core is exercised
  // at its full rate for a stretch.
  bit          steady = 1'b0;
  int          settings = 1;
  int unsigned cycles = 0;
  int          stall_left = 0;

  scalar_kalman_filter_core #(
    .PRELOAD_STEPS (PRELOAD),
    .FRACTION_BITS (FRAC)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_estimate_out (out_estimate_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d estimates still owed",
               $time, cycles, sb.expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result-side back-pressure. Most stalls are short; now and then a
  // long one lets the core finish its next item while the previous estimate
  // is still waiting to be taken.
  always @(posedge clk) begin : receiver
    int r;
    r = $urandom_range(0, 99);
    if (steady || !rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (r < 65) begin
      out_ready <= 1'b1;
    end else if (r < 92) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(10, 60);
    end
  end

  // Every transfer is observed here, on the values held before the edge.
  // The result is checked before the item of the same edge is noted, since
  // that result always belongs to an earlier item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_estimate(out_estimate_out);
      end
      if (in_valid && in_ready) begin
        sb.note_item(kind_t'(in_kind), in_sample);
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return KIND_SAMPLE;
    end else if (r < 80) begin
      return KIND_PRELOAD;
    end else if (r < 92) begin
      return KIND_RESTART;
    end
    return KIND_NONE;
  endfunction

  // Samples mostly scatter around a slowly moving true value, as a sensor
  // would deliver them; the rest are full-range noise and the extremes.
  function automatic logic [31:0] pick_sample(logic [31:0] center);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return $urandom;
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return center + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  // Register values: zero and all-ones, a single bit, realistic noise levels
  // up to a few hundred in Q16.16, and the full range.
  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return $urandom_range(0, 32'h0010_0000);
      4:       return $urandom_range(0, 32'h0100_0000);
      default: return 32'd1 << $urandom_range(0, 31);
    endcase
  endfunction

  // Drives one item and returns at the edge of its transfer, or after the gap
  // that follows it. Valid stays high when the next item follows without a gap.
  task automatic send_item(kind_t kind, logic [31:0] sample);
    int gap;
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_sample <= sample;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every owed estimate has been transferred.
  // The first edge lets the monitor note an item accepted at this very edge.
  task automatic wait_for_estimates();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Valid is left high so that writes can follow back to back.
  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(logic [31:0] init_err, logic [31:0] proc_noise,
                             logic [31:0] meas_noise);
    write_reg(REG_INITIAL_ERROR, init_err);
    write_reg(REG_PROCESS_NOISE, proc_noise);
    write_reg(REG_MEASUREMENT_NOISE, meas_noise);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  initial begin : main
    logic [31:0] center;
    int          p;
    int          n;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: covariance 1.0, process noise 10.0, measurement noise
    // 9.0. Extremes of the sample, the unused kind, a restart that keeps the
    // estimate, and preloads pulling the estimate across the full range.
    send_item(KIND_SAMPLE, 32'h0000_0000);
    send_item(KIND_SAMPLE, 32'h7FFF_FFFF);
    send_item(KIND_SAMPLE, 32'h8000_0000);
    send_item(KIND_NONE, $urandom);
    send_item(KIND_RESTART, 32'hFFFF_FFFF);
    send_item(KIND_PRELOAD, 32'h7FFF_FFFF);
    send_item(KIND_PRELOAD, 32'h8000_0000);
    send_item(KIND_SAMPLE, 32'h0001_8000);

    // All registers at their maximum: the prediction saturates, and the
    // write to the unused index must leave every register alone.
    wait_for_estimates();
    write_reg(REG_UNUSED, $urandom);
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_RESTART, 32'h0000_0000);
    send_item(KIND_SAMPLE, 32'h7FFF_FFFF);
    send_item(KIND_SAMPLE, 32'h8000_0000);
    send_item(KIND_PRELOAD, 32'h0000_0000);

    // All registers zero: after the restart the gain denominator is zero,
    // so the covariance stays zero and the estimate does not move.
    wait_for_estimates();
    load_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_RESTART, 32'h0000_0000);
    send_item(KIND_SAMPLE, 32'h7FFF_FFFF);
    send_item(KIND_PRELOAD, 32'h8000_0000);
    send_item(KIND_NONE, 32'h0000_0000);

    // Zero measurement noise: the gain is exactly one and the estimate jumps
    // straight to each sample.
    wait_for_estimates();
    load_config(32'h0002_0000, 32'h0000_0001, 32'h0000_0000);
    send_item(KIND_SAMPLE, 32'h1234_5678);
    send_item(KIND_SAMPLE, 32'h8000_0000);
    send_item(KIND_RESTART, $urandom);
    send_item(KIND_SAMPLE, 32'h7FFF_FFFF);

    // Random phases, each under a fresh register setting; the last one goes
    // back to the reset values. Within a phase the sender occasionally waits
    // for the core to drain, and stretches run with no gaps or stalls.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_estimates();
      if (p == RANDOM_PHASES - 1) begin
        load_config(32'd1 << FRAC, 32'd10 << FRAC, 32'd9 << FRAC);
      end else begin
        load_config(pick_reg_value(), pick_reg_value(), pick_reg_value());
      end
      center = $urandom;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        if (n % 16 == 0) begin
          center = center + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        end
        if ($urandom_range(0, 99) == 0) begin
          wait_for_estimates();
        end
        send_item(pick_kind(), pick_sample(center));
      end
    end
    steady = 1'b0;

    // Everything sent: collect the remaining estimates, then stay quiet long
    // enough for a stray extra result to show up.
    wait_for_estimates();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d preloads, %0d restarts, %0d unused kinds",
             sb.kind_count[KIND_SAMPLE], sb.kind_count[KIND_PRELOAD],
             sb.kind_count[KIND_RESTART], sb.kind_count[KIND_NONE]);
    $display("under %0d register settings; %0d estimates compared, %0d mismatches.",
             settings, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
